// ===== hdl/alpha_blend_pixel_pack_core_assert.svh =====
// Assertion macros for the alpha blend pixel packer.
// Included by alpha_blend_pixel_pack_core; depends on nothing else.
`ifndef ALPHA_BLEND_PIXEL_PACK_CORE_ASSERT_SVH
`define ALPHA_BLEND_PIXEL_PACK_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ABPP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("abpp same-cycle check failed");
`define ABPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("abpp next-cycle check failed");
`else
`define ABPP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ABPP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/abpp_pkg.sv =====
// Constants, register codes and constant-division helpers for the pixel packer.
// Used by alpha_blend_pixel_pack_core; depends on nothing else.
package abpp_pkg;

    localparam int NUM_CH   = 3;
    localparam int N_STAGES = 6;

    typedef enum logic [2:0] {
        CFG_RED_OFFSET   = 3'd0,
        CFG_RED_LENGTH   = 3'd1,
        CFG_GREEN_OFFSET = 3'd2,
        CFG_GREEN_LENGTH = 3'd3,
        CFG_BLUE_OFFSET  = 3'd4,
        CFG_BLUE_LENGTH  = 3'd5,
        CFG_PIXEL_BYTES  = 3'd6
    } t_cfg_index;

    // x / 255 == (x * DIV255_MAGIC) >> DIV255_SHIFT for every 16-bit x.
    localparam logic [16:0] DIV255_MAGIC = 17'h08081;
    localparam int          DIV255_SHIFT = 23;

    function automatic logic [31:0] byte_mask(input logic [2:0] pixel_bytes);
        logic [31:0] m;
        case (pixel_bytes)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // Field mask for reading a previous channel; lengths of zero or above eight read as 0.
    function automatic logic [7:0] read_mask(input logic [5:0] len);
        logic [7:0] m;
        case (len)
            6'd1:    m = 8'h01;
            6'd2:    m = 8'h03;
            6'd3:    m = 8'h07;
            6'd4:    m = 8'h0F;
            6'd5:    m = 8'h1F;
            6'd6:    m = 8'h3F;
            6'd7:    m = 8'h7F;
            6'd8:    m = 8'hFF;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // ceil(2^32 / (2^len - 1)); the quotient is exact for any 16-bit dividend.
    function automatic logic [31:0] expand_recip(input logic [5:0] len);
        logic [31:0] m;
        case (len)
            6'd2:    m = 32'h5555_5556;
            6'd3:    m = 32'h2492_4925;
            6'd4:    m = 32'h1111_1112;
            6'd5:    m = 32'h0842_1085;
            6'd6:    m = 32'h0410_4105;
            6'd7:    m = 32'h0204_0811;
            6'd8:    m = 32'h0101_0102;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

    // (2^(8*j) - 1) / 255: one set bit per whole byte of the field.
    function automatic logic [31:0] byte_repeat(input logic [2:0] j);
        logic [31:0] r;
        case (j)
            3'd0:    r = 32'h0000_0000;
            3'd1:    r = 32'h0000_0001;
            3'd2:    r = 32'h0000_0101;
            3'd3:    r = 32'h0001_0101;
            default: r = 32'h0101_0101;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/alpha_blend_pixel_pack_core.sv =====
// Alpha blend pixel packer: unpack, blend and repack one framebuffer pixel per request.
// Depends on abpp_pkg and alpha_blend_pixel_pack_core_assert.svh.
//
// Channel   Handshake              Payload
// s_axis    tvalid/tready          tdata: src_red, src_green, src_blue, coverage, prev_pixel
// m_axis    tvalid/tready          tdata: new_pixel; tuser: write_enable
// cfg       i_cfg_wr_en            i_cfg_index, i_cfg_wdata (no read-back)
//
// Six register stages: field extract, channel expand, blend, divide by 255,
// field rescale, pack and mask. One request is taken every cycle while m_axis
// accepts. Each stage holds its request while the next one is full, so a
// stall on m_axis fills the empty stages before s_axis_tready drops.
// Reset (synchronous, active low) empties the pipeline and loads the default
// 8:8:8 layout with four bytes per pixel.
`include "alpha_blend_pixel_pack_core_assert.svh"

module alpha_blend_pixel_pack_core
    import abpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] src_red, [15:8] src_green, [23:16] src_blue, [31:24] coverage,
    // [63:32] prev_pixel
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] new_pixel
    output logic [31:0] m_axis_tdata,
    // [0] write_enable
    output logic        m_axis_tuser
);

    // Configuration, indexed red, green, blue.
    logic [4:0] r_off [NUM_CH];
    logic [5:0] r_len [NUM_CH];
    logic [2:0] r_pixel_bytes;

    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES-1:0] w_rdy;

    // Stage registers.
    logic [7:0]  r1_src [NUM_CH];
    logic [15:0] r1_x   [NUM_CH];
    logic [7:0]  r1_cov;
    logic [31:0] r1_prev;

    logic [7:0]  r2_src [NUM_CH];
    logic [7:0]  r2_q   [NUM_CH];
    logic [7:0]  r2_cov;
    logic [31:0] r2_prev;

    logic [15:0] r3_y   [NUM_CH];
    logic        r3_we;
    logic [31:0] r3_prev;

    logic [7:0]  r4_v   [NUM_CH];
    logic        r4_we;
    logic [31:0] r4_prev;

    logic [31:0] r5_hi  [NUM_CH];
    logic [6:0]  r5_lo  [NUM_CH];
    logic        r5_we;
    logic [31:0] r5_prev;

    logic [31:0] r6_pixel;
    logic        r6_we;

    // Next values.
    logic [31:0] n_prev;
    logic [7:0]  n_field [NUM_CH];
    logic [15:0] n_x     [NUM_CH];
    logic [47:0] n_div   [NUM_CH];
    logic [7:0]  n_q     [NUM_CH];
    logic [15:0] n_sa    [NUM_CH];
    logic [15:0] n_pb    [NUM_CH];
    logic [16:0] n_y     [NUM_CH];
    logic [31:0] n_vprod [NUM_CH];
    logic [5:0]  n_wlen  [NUM_CH];
    logic [14:0] n_u     [NUM_CH];
    logic [14:0] n_w     [NUM_CH];
    logic [46:0] n_hprod [NUM_CH];
    logic [31:0] n_lprod [NUM_CH];
    logic [31:0] n_word;

    // A stage takes new data when it is empty or its content moves on.
    always_comb begin
        w_rdy[N_STAGES-1] = !r_vld[N_STAGES-1] || m_axis_tready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign s_axis_tready = w_rdy[0];
    assign m_axis_tvalid = r_vld[N_STAGES-1];
    assign m_axis_tdata  = r6_pixel;
    assign m_axis_tuser  = r6_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off[0]      <= 5'd16;
            r_len[0]      <= 6'd8;
            r_off[1]      <= 5'd8;
            r_len[1]      <= 6'd8;
            r_off[2]      <= 5'd0;
            r_len[2]      <= 6'd8;
            r_pixel_bytes <= 3'd4;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_RED_OFFSET:   r_off[0]      <= i_cfg_wdata[4:0];
                CFG_RED_LENGTH:   r_len[0]      <= i_cfg_wdata;
                CFG_GREEN_OFFSET: r_off[1]      <= i_cfg_wdata[4:0];
                CFG_GREEN_LENGTH: r_len[1]      <= i_cfg_wdata;
                CFG_BLUE_OFFSET:  r_off[2]      <= i_cfg_wdata[4:0];
                CFG_BLUE_LENGTH:  r_len[2]      <= i_cfg_wdata;
                CFG_PIXEL_BYTES:  r_pixel_bytes <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        n_prev = s_axis_tdata[63:32] & byte_mask(r_pixel_bytes);
        n_word = 32'h0;
        for (int c = 0; c < NUM_CH; c++) begin
            // Stage 1: pull the old field out and scale it by 255.
            n_field[c] = 8'(n_prev >> r_off[c]) & read_mask(r_len[c]);
            n_x[c]     = {n_field[c], 8'h00} - {8'h00, n_field[c]};
            // Stage 2: divide by the field maximum; a one-bit field divides by one.
            n_div[c]   = 48'(r1_x[c]) * 48'(expand_recip(r_len[c]));
            n_q[c]     = (r_len[c] == 6'd1) ? r1_x[c][7:0] : n_div[c][39:32];
            // Stage 3: weighted sum with rounding.
            n_sa[c]    = 16'(r2_src[c]) * 16'(r2_cov);
            n_pb[c]    = 16'(r2_q[c]) * 16'(8'd255 - r2_cov);
            n_y[c]     = 17'(n_sa[c]) + 17'(n_pb[c]) + 17'd127;
            // Stage 4: divide by 255.
            n_vprod[c] = 32'(r3_y[c]) * 32'(DIV255_MAGIC);
            // Stage 5: v * (2^L - 1) / 255 split into whole bytes of the field
            // plus the leftover L mod 8 bits, which needs a small division.
            n_wlen[c]  = (r_len[c] >= 6'd32) ? 6'd32 : r_len[c];
            n_u[c]     = 15'(r4_v[c]) << n_wlen[c][2:0];
            n_w[c]     = n_u[c] - 15'(r4_v[c]);
            n_hprod[c] = 47'(n_u[c]) * 47'(byte_repeat(n_wlen[c][5:3]));
            n_lprod[c] = 32'(n_w[c]) * 32'(DIV255_MAGIC);
            // Stage 6: place the field and merge.
            n_word     = n_word | ((r5_hi[c] + 32'(r5_lo[c])) << r_off[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r1_src[c] <= s_axis_tdata[c*8 +: 8];
                r1_x[c]   <= n_x[c];
            end
            r1_cov  <= s_axis_tdata[31:24];
            r1_prev <= n_prev;
        end
        if (w_rdy[1]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r2_src[c] <= r1_src[c];
                r2_q[c]   <= n_q[c];
            end
            r2_cov  <= r1_cov;
            r2_prev <= r1_prev;
        end
        if (w_rdy[2]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r3_y[c] <= n_y[c][15:0];
            end
            r3_we   <= (r2_cov != 8'd0);
            r3_prev <= r2_prev;
        end
        if (w_rdy[3]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r4_v[c] <= n_vprod[c][DIV255_SHIFT +: 8];
            end
            r4_we   <= r3_we;
            r4_prev <= r3_prev;
        end
        if (w_rdy[4]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r5_hi[c] <= n_hprod[c][31:0];
                r5_lo[c] <= n_lprod[c][DIV255_SHIFT +: 7];
            end
            r5_we   <= r4_we;
            r5_prev <= r4_prev;
        end
        if (w_rdy[5]) begin
            // Zero coverage passes the masked old pixel and suppresses the write.
            r6_pixel <= r5_we ? (n_word & byte_mask(r_pixel_bytes)) : r5_prev;
            r6_we    <= r5_we;
        end
    end

    `ABPP_ASSERT_SAME(a_empty_front_ready, i_clk, i_rst_n, !r_vld[0], s_axis_tready)
    `ABPP_ASSERT_SAME(a_empty_out_ready, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)
    `ABPP_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_vld[0])
    `ABPP_ASSERT_NEXT(a_last_moves_out, i_clk, i_rst_n,
        r_vld[N_STAGES-2] && w_rdy[N_STAGES-1], m_axis_tvalid)

endmodule

// ===== tb/sv/alpha_blend_pixel_pack_core_tb.sv =====
// Self-checking testbench for alpha_blend_pixel_pack_core: blends pixels under a range
// of channel layouts and compares every packed word against an in-bench predictor.
// Depends on abpp_pkg and the RTL of alpha_blend_pixel_pack_core.
module alpha_blend_pixel_pack_core_tb
    import abpp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CFG_UNUSED_INDEX = 3'd7;
    localparam int         CYCLE_LIMIT      = 300000;
    localparam int         LONG_HOLD        = 300;

    typedef struct {
        logic [7:0]  src_red;
        logic [7:0]  src_green;
        logic [7:0]  src_blue;
        logic [7:0]  coverage;
        logic [31:0] prev_pixel;
        int          gap;
    } t_pixel_req;

    typedef struct {
        logic [31:0] new_pixel;
        logic        write_enable;
    } t_blend_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = 3'd0;
    logic [5:0]  i_cfg_wdata = 6'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = 64'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    // Layout as the block holds it, starting from its reset values.
    logic [4:0]  lay_off [3] = '{5'd16, 5'd8, 5'd0};
    logic [5:0]  lay_len [3] = '{6'd8, 6'd8, 6'd8};
    logic [2:0]  lay_bytes = 3'd4;

    t_pixel_req  pixel_q [$];
    t_blend_res  blend_q [$];
    t_pixel_req  on_bus;
    int          idle_count = 0;
    int          rx_wait = 0;
    int          rx_style = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_skipped = 0;
    int          n_layouts = 1;
    int          n_errors = 0;
    int          cycles = 0;

    alpha_blend_pixel_pack_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("alpha_blend_pixel_pack_core: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [31:0] stored_mask();
        int n;
        n = (lay_bytes > 3'd4) ? 4 : int'(lay_bytes);
        if (n == 4) return 32'hFFFF_FFFF;
        return (32'd1 << (n * 8)) - 32'd1;
    endfunction

    // Previous channel widened to 8 bits; unreadable lengths give 0.
    function automatic logic [31:0] widen_channel(input logic [31:0] word,
                                                  input logic [4:0] off,
                                                  input logic [5:0] len);
        logic [31:0] fmax;
        if (len == 6'd0 || len > 6'd8) return 32'd0;
        fmax = (32'd1 << len) - 32'd1;
        return ((word >> off) & fmax) * 32'd255 / fmax;
    endfunction

    function automatic logic [31:0] place_channel(input logic [31:0] v,
                                                  input logic [4:0] off,
                                                  input logic [5:0] len);
        logic [63:0] fmax;
        logic [63:0] scaled;
        if (len == 6'd0) return 32'd0;
        fmax = (len >= 6'd32) ? 64'hFFFF_FFFF : (64'd1 << len) - 64'd1;
        scaled = ((64'(v) * fmax) / 64'd255) << off;
        return scaled[31:0];
    endfunction

    function automatic logic [31:0] mix255(input logic [31:0] src, input logic [31:0] prev,
                                           input logic [31:0] a);
        return (src * a + prev * (32'd255 - a) + 32'd127) / 32'd255;
    endfunction

    function automatic t_blend_res predict_pixel(input t_pixel_req req);
        t_blend_res  res;
        logic [31:0] mask;
        logic [31:0] prev;
        logic [31:0] src [3];
        logic [31:0] word;
        mask = stored_mask();
        prev = req.prev_pixel & mask;
        src = '{32'(req.src_red), 32'(req.src_green), 32'(req.src_blue)};
        if (req.coverage == 8'd0) begin
            res.new_pixel = prev;
            res.write_enable = 1'b0;
            return res;
        end
        word = 32'd0;
        for (int c = 0; c < 3; c++) begin
            word |= place_channel(mix255(src[c], widen_channel(prev, lay_off[c], lay_len[c]),
                                         32'(req.coverage)), lay_off[c], lay_len[c]);
        end
        res.new_pixel = word & mask;
        res.write_enable = 1'b1;
        return res;
    endfunction

    // ---------------------------------------------------------------- driver

    function automatic int idle_cycles(input int style);
        case (style)
            0:       return 0;
            1:       return $urandom_range(0, 18);
            default: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            idle_count <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                blend_q.push_back(predict_pixel(on_bus));
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pixel_q.size() > 0 && idle_count >= pixel_q[0].gap) begin
                    on_bus = pixel_q.pop_front();
                    s_axis_tdata <= {on_bus.prev_pixel, on_bus.coverage, on_bus.src_blue,
                                     on_bus.src_green, on_bus.src_red};
                    s_axis_tvalid <= 1'b1;
                    idle_count <= 0;
                end else begin
                    s_axis_tvalid <= 1'b0;
                    if (pixel_q.size() > 0) idle_count <= idle_count + 1;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        t_blend_res exp_res;
        int         stall;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            n_checked++;
            if (blend_q.size() == 0) begin
                $error("unexpected result: new_pixel %h write_enable %b",
                       m_axis_tdata, m_axis_tuser);
                n_errors++;
            end else begin
                exp_res = blend_q.pop_front();
                if (!exp_res.write_enable) n_skipped++;
                if (m_axis_tdata !== exp_res.new_pixel) begin
                    $error("new_pixel: expected %h, got %h", exp_res.new_pixel, m_axis_tdata);
                    n_errors++;
                end
                if (m_axis_tuser !== exp_res.write_enable) begin
                    $error("write_enable: expected %b, got %b",
                           exp_res.write_enable, m_axis_tuser);
                    n_errors++;
                end
            end
            // Twice in the run the sink stops long enough for the pipeline to back up.
            stall = (n_checked == 150 || n_checked == 600) ? LONG_HOLD : idle_cycles(rx_style);
            rx_wait <= stall;
            m_axis_tready <= (stall == 0);
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_axis_tready <= (rx_wait == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- stimulus

    // Sampled on the falling edge so the queues are stable.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pixel_q.size() != 0 || s_axis_tvalid || blend_q.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= 6'(val);
        case (idx)
            CFG_RED_OFFSET:   lay_off[0] = 5'(val);
            CFG_RED_LENGTH:   lay_len[0] = 6'(val);
            CFG_GREEN_OFFSET: lay_off[1] = 5'(val);
            CFG_GREEN_LENGTH: lay_len[1] = 6'(val);
            CFG_BLUE_OFFSET:  lay_off[2] = 5'(val);
            CFG_BLUE_LENGTH:  lay_len[2] = 6'(val);
            CFG_PIXEL_BYTES:  lay_bytes = 3'(val);
            default: ;
        endcase
    endtask

    task automatic cfg_release();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_layout(input int ro, input int rl, input int go, input int gl,
                              input int bo, input int bl, input int pb);
        wait_drained();
        write_reg(CFG_RED_OFFSET, ro);
        write_reg(CFG_RED_LENGTH, rl);
        write_reg(CFG_GREEN_OFFSET, go);
        write_reg(CFG_GREEN_LENGTH, gl);
        write_reg(CFG_BLUE_OFFSET, bo);
        write_reg(CFG_BLUE_LENGTH, bl);
        write_reg(CFG_PIXEL_BYTES, pb);
        cfg_release();
        n_layouts++;
    endtask

    task automatic push_pixel(input int r, input int g, input int b, input int cov,
                              input logic [31:0] prev, input int gap);
        t_pixel_req req;
        req.src_red = 8'(r);
        req.src_green = 8'(g);
        req.src_blue = 8'(b);
        req.coverage = 8'(cov);
        req.prev_pixel = prev;
        req.gap = gap;
        pixel_q.push_back(req);
    endtask

    task automatic queue_random(input int n, input int tx_style, input int rx_sel);
        int          cov;
        logic [31:0] prev;
        @(negedge i_clk);
        rx_style = rx_sel;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0:       cov = 0;
                1:       cov = 255;
                2:       cov = $urandom_range(0, 1) ? 1 : 254;
                default: cov = $urandom_range(0, 255);
            endcase
            case ($urandom_range(0, 7))
                0:       prev = 32'd0;
                1:       prev = 32'hFFFF_FFFF;
                2, 3:    prev = $urandom() & stored_mask();
                default: prev = $urandom();
            endcase
            push_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), cov, prev, idle_cycles(tx_style));
        end
    endtask

    // Lengths that can be read back dominate; zero and oversized ones appear now and then.
    function automatic int rand_len();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return $urandom_range(9, 63);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default 8:8:8 layout: coverage and intensity extremes.
        @(negedge i_clk);
        rx_style = 1;
        push_pixel(8'hFF, 8'hFF, 8'hFF, 0, 32'hFFFF_FFFF, 0);
        push_pixel(8'h12, 8'h34, 8'h56, 0, 32'h0000_0000, 3);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 255, 32'h0000_0000, 0);
        push_pixel(8'h00, 8'h00, 8'h00, 255, 32'hFFFF_FFFF, 0);
        push_pixel(8'hFF, 8'h00, 8'hFF, 1, 32'h0000_0000, 18);
        push_pixel(8'h00, 8'hFF, 8'h00, 1, 32'h00FF_FFFF, 0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 254, 32'h0000_0000, 1);
        push_pixel(8'h00, 8'h00, 8'h00, 254, 32'h00FF_FFFF, 0);
        push_pixel(8'h80, 8'h7F, 8'h01, 128, 32'h1234_5678, 0);
        push_pixel(8'h01, 8'hFE, 8'h80, 127, 32'hFF80_7F01, 5);
        push_pixel(8'hAA, 8'h55, 8'hC3, 200, 32'hA5A5_A5A5, 0);
        push_pixel(8'h55, 8'hAA, 8'h3C, 55, 32'h5A5A_5A5A, 0);
        for (int k = 0; k < 8; k++) begin
            push_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(1, 255), $urandom(), idle_cycles(2));
        end

        queue_random(100, 0, 0);

        // 5:6:5 in two bytes.
        set_layout(11, 5, 5, 6, 0, 5, 2);
        queue_random(100, 0, 2);

        // Field at the top bit, a disabled channel, oversized lengths, bytes beyond four,
        // then a write to an index the block does not decode.
        set_layout(31, 32, 0, 0, 24, 63, 7);
        write_reg(CFG_UNUSED_INDEX, 6'h3F);
        cfg_release();
        queue_random(100, 1, 1);

        // One-bit fields packed into a single byte.
        set_layout(0, 1, 1, 1, 2, 1, 1);
        queue_random(90, 2, 0);

        // Nothing survives the mask.
        set_layout(0, 8, 8, 8, 16, 8, 0);
        queue_random(60, 2, 2);

        // Swapped 8:8:8 in three bytes with overlapping red and green.
        set_layout(0, 8, 4, 8, 16, 8, 3);
        queue_random(90, 1, 0);

        // Unreadable but writable nine-bit and 31-bit fields, a seven-bit field and five bytes.
        set_layout(23, 9, 10, 31, 1, 7, 5);
        queue_random(90, 0, 1);

        for (int p = 0; p < 5; p++) begin
            set_layout($urandom_range(0, 31), rand_len(), $urandom_range(0, 31), rand_len(),
                       $urandom_range(0, 31), rand_len(), $urandom_range(0, 7));
            queue_random(80, p % 3, (p + 1) % 3);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Blended %0d pixels across %0d channel layouts, %0d of them with no coverage.",
                 n_sent, n_layouts, n_skipped);
        if (n_errors == 0) begin
            $display("alpha_blend_pixel_pack_core: match");
        end else begin
            $display("alpha_blend_pixel_pack_core: mismatch");
        end
        $finish;
    end

endmodule
